// ===== src/pcm_pkg.sv =====
// Shared constants, types and state encoding for the piecewise-linear CDF map.
`timescale 1ns / 1ps
`default_nettype none
package pcm_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int FX_W       = 32;
  localparam int PROD_W     = 2 * FX_W;

  localparam logic [FX_W-1:0] ONE_FX = 32'h8000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALK_CMP,
    ST_LO,
    ST_LO_CAP,
    ST_HI,
    ST_HI_CAP,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [FX_W-1:0]   bp;
    logic [FX_W-1:0]   cdf;
  } tbl_wr_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [FX_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/pcm_table.sv =====
// Breakpoint and CDF value memories, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pcm_table
  import pcm_pkg::*;
(
  input  wire logic              clk,
  input  wire tbl_wr_t           wr,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [FX_W-1:0]   bp_q,
  output logic      [FX_W-1:0]   cdf_q
);

  logic [FX_W-1:0] bp_mem  [MAX_POINTS];
  logic [FX_W-1:0] cdf_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bp_mem[wr.addr]  <= wr.bp;
      cdf_mem[wr.addr] <= wr.cdf;
    end
    bp_q  <= bp_mem[rd_addr];
    cdf_q <= cdf_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/pcm_divider.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module pcm_divider
  import pcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

  logic              running;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [FX_W-1:0]   rem;
  logic [FX_W-1:0]   divisor;
  logic [PROD_W-1:0] quo;

  logic [FX_W:0] trial;
  logic [FX_W:0] diff;
  logic          fits;

  // shift in the next dividend bit, subtract if the divisor fits
  assign trial = {rem, quo[PROD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && (step == LAST_STEP);
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (running) begin
      rem <= fits ? diff[FX_W-1:0] : trial[FX_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== src/piecewise_linear_cdf_map_core.sv =====
// Top level of the piecewise-linear CDF map: sequencer, segment walk and interpolation.
//
//  channel   signals                                         direction  transaction when
//  --------  ----------------------------------------------  ---------  -----------------------
//  command   start busy opcode entry_index breakpoint         in         start & !busy
//            cdf_value sample last_sample
//  result    result_valid mapped_value segment_index          out        result_valid (1 cycle)
//            degenerate_segment
//  config    cfg_valid cfg_ready cfg_data                     in         cfg_valid & cfg_ready
//
//  A load writes the tables directly and busy stays low; it gives no result.
//  A map holds busy while the pointer walks forward (a table read, then a compare, for
//  each breakpoint it steps over), then while both segment ends are read, the product
//  is formed and the 64 divider steps run to done. The result strobe rises in the
//  same cycle that busy drops.
//  A zero-width segment skips multiply and divide.
//  Reset (rst, synchronous) clears the sequencer, the segment pointer and sets
//  points_in_use to 1024; table contents are undefined until loaded.
//  The receiver cannot stall: each result is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_cdf_map_core
  import pcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              opcode,
  input  wire logic [ADDR_W-1:0] entry_index,
  input  wire logic [FX_W-1:0]   breakpoint,
  input  wire logic [FX_W-1:0]   cdf_value,
  input  wire logic [FX_W-1:0]   sample,
  input  wire logic              last_sample,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data,
  output logic                   result_valid,
  output logic      [FX_W-1:0]   mapped_value,
  output logic      [CNT_W-1:0]  segment_index,
  output logic                   degenerate_segment
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  state_t state, state_next;

  // control registers
  logic [CNT_W-1:0] points_in_use;
  logic [CNT_W-1:0] segment_pointer;

  // per-item datapath
  logic [CNT_W-1:0]  j;
  logic [FX_W-1:0]   x;
  logic              last;
  logic [FX_W-1:0]   bp_lo, c_lo, bp_hi, c_hi;
  logic [FX_W-1:0]   dx_mag, dc_mag, den_mag;
  logic              neg;
  logic              degen;
  logic [PROD_W-1:0] prod;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  j_start;
  logic [CNT_W-1:0]  jm1;
  logic [ADDR_W-1:0] rd_addr;
  logic [FX_W-1:0]   bp_q, cdf_q;
  logic              accept;
  logic [FX_W:0]     dx, dc, den;
  logic [FX_W-1:0]   interp;

  tbl_wr_t  tbl_wr;
  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [FX_W-1:0] sat_one(input logic [FX_W-1:0] v);
    return (v > ONE_FX) ? ONE_FX : v;
  endfunction

  function automatic logic [FX_W-1:0] mag33(input logic [FX_W:0] v);
    logic [FX_W:0] m;
    m = v[FX_W] ? (~v + (FX_W+1)'(1)) : v;
    return m[FX_W-1:0];
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // effective table size and starting pointer
  assign n       = (points_in_use > MAX_CNT) ? MAX_CNT : points_in_use;
  assign j_start = (segment_pointer > n) ? n : segment_pointer;
  assign jm1     = j - CNT_W'(1);

  // loads go straight into the tables
  assign tbl_wr.en   = accept && (opcode == OP_LOAD);
  assign tbl_wr.addr = entry_index;
  assign tbl_wr.bp   = sat_one(breakpoint);
  assign tbl_wr.cdf  = sat_one(cdf_value);

  pcm_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .bp_q    (bp_q),
    .cdf_q   (cdf_q)
  );

  assign div_req.start    = (state == ST_DIV);
  assign div_req.dividend = prod;
  assign div_req.divisor  = den_mag;

  pcm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // signed segment deltas, 33 bits
  assign dx  = {1'b0, x}     - {1'b0, bp_lo};
  assign dc  = {1'b0, c_hi}  - {1'b0, c_lo};
  assign den = {1'b0, bp_hi} - {1'b0, bp_lo};

  // c_lo +/- quotient, clamped to [0, 1.0], or c_hi for a zero-width segment; the quotient
  // magnitude fits below 2^32 whenever no clamp applies
  always_comb begin
    if (degen) begin
      interp = c_hi;
    end else if (neg) begin
      interp = (div_rsp.quotient > PROD_W'(c_lo)) ? '0
             : c_lo - div_rsp.quotient[FX_W-1:0];
    end else begin
      interp = (div_rsp.quotient > PROD_W'(ONE_FX - c_lo)) ? ONE_FX
             : c_lo + div_rsp.quotient[FX_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = j[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_MAP)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        state_next = (j < n) ? ST_WALK_CMP : ST_LO;
      end
      ST_WALK_CMP: begin
        state_next = (x >= bp_q) ? ST_WALK : ST_LO;
      end
      ST_LO: begin
        rd_addr    = jm1[ADDR_W-1:0];
        state_next = (j == '0) ? ST_HI : ST_LO_CAP;
      end
      ST_LO_CAP: begin
        state_next = ST_HI;
      end
      ST_HI: begin
        state_next = (j >= n) ? ST_CALC : ST_HI_CAP;
      end
      ST_HI_CAP: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = (den == '0) ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use   <= MAX_CNT;
      segment_pointer <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= (state == ST_FIN);
      if (cfg_valid && cfg_ready) begin
        points_in_use <= cfg_data;
      end
      if (state == ST_FIN) begin
        segment_pointer <= last ? '0 : j;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        j    <= j_start;
        x    <= sat_one(sample);
        last <= last_sample;
      end
      ST_WALK_CMP: begin
        if (x >= bp_q) begin
          j <= j + CNT_W'(1);
        end
      end
      ST_LO: begin
        if (j == '0) begin
          bp_lo <= '0;
          c_lo  <= '0;
        end
      end
      ST_LO_CAP: begin
        bp_lo <= bp_q;
        c_lo  <= cdf_q;
      end
      ST_HI: begin
        if (j >= n) begin
          bp_hi <= ONE_FX;
          c_hi  <= ONE_FX;
        end
      end
      ST_HI_CAP: begin
        bp_hi <= bp_q;
        c_hi  <= cdf_q;
      end
      ST_CALC: begin
        dx_mag  <= mag33(dx);
        dc_mag  <= mag33(dc);
        den_mag <= mag33(den);
        neg     <= dx[FX_W] ^ dc[FX_W] ^ den[FX_W];
        degen   <= (den == '0);
      end
      ST_MUL: begin
        prod <= PROD_W'(dx_mag) * PROD_W'(dc_mag);
      end
      ST_FIN: begin
        mapped_value       <= interp;
        segment_index      <= j;
        degenerate_segment <= degen;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
